/* rtl/clustered_max_weight_selection_bnb_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the clustered selection core
// Shared macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CLUSTERED_MAX_WEIGHT_SELECTION_BNB_CORE_DEFINES_SVH
`define CLUSTERED_MAX_WEIGHT_SELECTION_BNB_CORE_DEFINES_SVH

// Check a consequence in the cycle after the antecedent
`define CMWSB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check a consequence in the same cycle as the antecedent
`define CMWSB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/cmwsb_pkg.sv */
// ----------------------------------------------------------------------------
// cmwsb_pkg
// Sizes, codes, state types and the read channel shared by the graph store
// and the search engine.
// ----------------------------------------------------------------------------
package cmwsb_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_VERTICES = 256;
  localparam int WEIGHT_BITS  = 16;

  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int CC_W   = CL_W + 1;
  localparam int VX_W   = $clog2(MAX_VERTICES);
  localparam int VC_W   = VX_W + 1;
  localparam int EA_W   = 2 * VX_W;
  localparam int MA_W   = VX_W + CL_W;
  localparam int PA_W   = 2 * CL_W;
  localparam int DEG_W  = 24;
  localparam int VAL_W  = 32;
  localparam int NODE_W = 48;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_SOLVE  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_APPEND,
    ST_E_EDGE, ST_E_VCV, ST_E_DU_RD, ST_E_DU_WR, ST_E_DV_RD, ST_E_DV_WR,
    ST_E_MU_RD, ST_E_MU_WR, ST_E_MV_RD, ST_E_MV_WR, ST_E_PM_RD, ST_E_PM_WR
  } store_st_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SORT_C, S_SORT_X0, S_SORT_X1, S_SORT_Y0, S_SORT_Y1, S_SORT_W,
    S_SORT_SEL, S_SEED, S_ENTER, S_EV_CHK, S_EV_T0, S_EV_T1, S_EV_T2,
    S_EV_T3, S_EV_DONE, S_LOOP, S_LOAD, S_CP0, S_CP1, S_OUT
  } search_st_t;

  typedef enum logic [1:0] {
    MODE_VAL, MODE_PAIR, MODE_VCM
  } mode_t;

  typedef struct packed {
    logic [EA_W-1:0] edge_ra;
    logic [MA_W-1:0] vcm_ra;
    logic [PA_W-1:0] cpm_ra;
    logic [VX_W-1:0] deg_ra;
    logic [CL_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] edge_q;
    logic [WEIGHT_BITS-1:0] vcm_q;
    logic [WEIGHT_BITS-1:0] cpm_q;
    logic [DEG_W-1:0]       deg_q;
    logic [VC_W-1:0]        size;
    logic [VC_W-1:0]        start;
    logic [CC_W-1:0]        count;
  } rd_rsp_t;

endpackage

/* rtl/cmwsb_store.sv */
// ----------------------------------------------------------------------------
// cmwsb_store
// Graph memories: edge matrix, degrees, vertex-to-cluster maxima, cluster
// pair maxima and vertex clusters. Runs the clearing pass, cluster appends
// and edge loads, and serves reads to the search engine when idle.
// ----------------------------------------------------------------------------
module cmwsb_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_start,
  input  logic                         load_edge,
  input  logic [cmwsb_pkg::VC_W-1:0]   size_in,
  input  logic [cmwsb_pkg::VX_W-1:0]   u_in,
  input  logic [cmwsb_pkg::VX_W-1:0]   v_in,
  input  logic [15:0]                  w_in,
  input  cmwsb_pkg::rd_req_t           req,
  output cmwsb_pkg::rd_rsp_t           rsp,
  output logic                         busy
);

  cmwsb_pkg::store_st_t st, st_next;

  logic [cmwsb_pkg::EA_W-1:0]        clr;
  logic [cmwsb_pkg::CC_W-1:0]        cc;
  logic [cmwsb_pkg::VC_W-1:0]        vc;
  logic [cmwsb_pkg::VC_W-1:0]        sz;
  logic [cmwsb_pkg::VC_W-1:0]        ap_i;
  logic [cmwsb_pkg::VX_W-1:0]        u, v;
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] w;
  logic [cmwsb_pkg::CL_W-1:0]        cu, cv;
  logic [cmwsb_pkg::VC_W-1:0]        sizes  [cmwsb_pkg::MAX_CLUSTERS];
  logic [cmwsb_pkg::VC_W-1:0]        starts [cmwsb_pkg::MAX_CLUSTERS];

  // memory ports
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] edge_mem [2**cmwsb_pkg::EA_W];
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] vcm_mem  [2**cmwsb_pkg::MA_W];
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] cpm_mem  [2**cmwsb_pkg::PA_W];
  logic [cmwsb_pkg::DEG_W-1:0]       deg_mem  [cmwsb_pkg::MAX_VERTICES];
  logic [cmwsb_pkg::CL_W-1:0]        vcl_mem  [cmwsb_pkg::MAX_VERTICES];

  logic                              e_we, m_we, p_we, d_we, l_we;
  logic [cmwsb_pkg::EA_W-1:0]        e_wa, e_ra;
  logic [cmwsb_pkg::MA_W-1:0]        m_wa, m_ra;
  logic [cmwsb_pkg::PA_W-1:0]        p_wa, p_ra;
  logic [cmwsb_pkg::VX_W-1:0]        d_wa, d_ra, l_wa, l_ra;
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] e_wd, m_wd, p_wd;
  logic [cmwsb_pkg::DEG_W-1:0]       d_wd;
  logic [cmwsb_pkg::CL_W-1:0]        l_wd;
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] e_q, m_q, p_q;
  logic [cmwsb_pkg::DEG_W-1:0]       d_q;
  logic [cmwsb_pkg::CL_W-1:0]        l_q;

  logic [cmwsb_pkg::DEG_W:0]         dsum;
  logic [cmwsb_pkg::VX_W-1:0]        vmin, vmax;
  logic [cmwsb_pkg::CL_W-1:0]        cmin, cmax;
  logic                              ap_last, edge_ok, app_ok;

  assign vmin    = (u < v) ? u : v;
  assign vmax    = (u < v) ? v : u;
  assign cmin    = (cu < cv) ? cu : cv;
  assign cmax    = (cu < cv) ? cv : cu;
  assign dsum    = {1'b0, d_q} + (cmwsb_pkg::DEG_W + 1)'(w);
  assign ap_last = (ap_i + cmwsb_pkg::VC_W'(1)) == sz;
  assign edge_ok = ({1'b0, u_in} < vc) && ({1'b0, v_in} < vc);
  assign app_ok  = (size_in != '0) && (cc < cmwsb_pkg::CC_W'(cmwsb_pkg::MAX_CLUSTERS)) &&
                   (size_in <= cmwsb_pkg::VC_W'(cmwsb_pkg::MAX_VERTICES) - vc);

  // state register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= cmwsb_pkg::ST_CLEAR;
      clr <= '0;
      cc  <= '0;
      vc  <= '0;
    end else begin
      st <= st_next;
      if (st == cmwsb_pkg::ST_CLEAR) begin
        clr <= clr + cmwsb_pkg::EA_W'(1);
      end
      if (st == cmwsb_pkg::ST_APPEND && ap_last) begin
        cc <= cc + cmwsb_pkg::CC_W'(1);
        vc <= vc + sz;
      end
    end
  end

  // latch the request and the endpoint clusters
  always_ff @(posedge clk) begin
    case (st)
      cmwsb_pkg::ST_IDLE: begin
        if (load_start) begin
          u    <= u_in;
          v    <= v_in;
          w    <= w_in[cmwsb_pkg::WEIGHT_BITS-1:0];
          sz   <= size_in;
          ap_i <= '0;
        end
      end
      cmwsb_pkg::ST_APPEND: begin
        ap_i <= ap_i + cmwsb_pkg::VC_W'(1);
        if (ap_last) begin
          sizes[cc[cmwsb_pkg::CL_W-1:0]]  <= sz;
          starts[cc[cmwsb_pkg::CL_W-1:0]] <= vc;
        end
      end
      cmwsb_pkg::ST_E_VCV:   cu <= l_q;
      cmwsb_pkg::ST_E_DU_RD: cv <= l_q;
      default: ;
    endcase
  end

  // next state and memory control
  always_comb begin
    st_next = st;
    e_we = 1'b0; m_we = 1'b0; p_we = 1'b0; d_we = 1'b0; l_we = 1'b0;
    e_wa = '0; m_wa = '0; p_wa = '0; d_wa = '0; l_wa = '0;
    e_wd = '0; m_wd = '0; p_wd = '0; d_wd = '0; l_wd = '0;
    e_ra = req.edge_ra;
    m_ra = req.vcm_ra;
    p_ra = req.cpm_ra;
    d_ra = req.deg_ra;
    l_ra = u;
    case (st)
      cmwsb_pkg::ST_CLEAR: begin
        e_we = 1'b1;
        e_wa = clr;
        m_we = (clr[cmwsb_pkg::EA_W-1:cmwsb_pkg::MA_W] == '0);
        m_wa = clr[cmwsb_pkg::MA_W-1:0];
        p_we = (clr[cmwsb_pkg::EA_W-1:cmwsb_pkg::PA_W] == '0);
        p_wa = clr[cmwsb_pkg::PA_W-1:0];
        d_we = (clr[cmwsb_pkg::EA_W-1:cmwsb_pkg::VX_W] == '0);
        d_wa = clr[cmwsb_pkg::VX_W-1:0];
        if (clr == '1) begin
          st_next = cmwsb_pkg::ST_IDLE;
        end
      end
      cmwsb_pkg::ST_IDLE: begin
        if (load_start) begin
          if (load_edge) begin
            if (edge_ok) st_next = cmwsb_pkg::ST_E_EDGE;
          end else if (app_ok) begin
            st_next = cmwsb_pkg::ST_APPEND;
          end
        end
      end
      cmwsb_pkg::ST_APPEND: begin
        l_we = 1'b1;
        l_wa = cmwsb_pkg::VX_W'(vc + ap_i);
        l_wd = cc[cmwsb_pkg::CL_W-1:0];
        if (ap_last) st_next = cmwsb_pkg::ST_IDLE;
      end
      // one symmetric matrix entry held at (min, max)
      cmwsb_pkg::ST_E_EDGE: begin
        e_we    = 1'b1;
        e_wa    = {vmin, vmax};
        e_wd    = w;
        l_ra    = u;
        st_next = cmwsb_pkg::ST_E_VCV;
      end
      cmwsb_pkg::ST_E_VCV: begin
        l_ra    = v;
        st_next = cmwsb_pkg::ST_E_DU_RD;
      end
      cmwsb_pkg::ST_E_DU_RD: begin
        d_ra    = u;
        st_next = cmwsb_pkg::ST_E_DU_WR;
      end
      cmwsb_pkg::ST_E_DU_WR: begin
        d_we    = 1'b1;
        d_wa    = u;
        d_wd    = dsum[cmwsb_pkg::DEG_W] ? '1 : dsum[cmwsb_pkg::DEG_W-1:0];
        st_next = cmwsb_pkg::ST_E_DV_RD;
      end
      cmwsb_pkg::ST_E_DV_RD: begin
        d_ra    = v;
        st_next = cmwsb_pkg::ST_E_DV_WR;
      end
      cmwsb_pkg::ST_E_DV_WR: begin
        d_we    = 1'b1;
        d_wa    = v;
        d_wd    = dsum[cmwsb_pkg::DEG_W] ? '1 : dsum[cmwsb_pkg::DEG_W-1:0];
        st_next = cmwsb_pkg::ST_E_MU_RD;
      end
      cmwsb_pkg::ST_E_MU_RD: begin
        m_ra    = {u, cv};
        st_next = cmwsb_pkg::ST_E_MU_WR;
      end
      cmwsb_pkg::ST_E_MU_WR: begin
        m_we    = (w > m_q);
        m_wa    = {u, cv};
        m_wd    = w;
        st_next = cmwsb_pkg::ST_E_MV_RD;
      end
      cmwsb_pkg::ST_E_MV_RD: begin
        m_ra    = {v, cu};
        st_next = cmwsb_pkg::ST_E_MV_WR;
      end
      cmwsb_pkg::ST_E_MV_WR: begin
        m_we    = (w > m_q);
        m_wa    = {v, cu};
        m_wd    = w;
        st_next = cmwsb_pkg::ST_E_PM_RD;
      end
      cmwsb_pkg::ST_E_PM_RD: begin
        p_ra    = {cmin, cmax};
        st_next = cmwsb_pkg::ST_E_PM_WR;
      end
      cmwsb_pkg::ST_E_PM_WR: begin
        p_we    = (cu != cv) && (w > p_q);
        p_wa    = {cmin, cmax};
        p_wd    = w;
        st_next = cmwsb_pkg::ST_IDLE;
      end
      default: st_next = cmwsb_pkg::ST_IDLE;
    endcase
  end

  // synchronous memories with registered read data
  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    e_q <= edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) vcm_mem[m_wa] <= m_wd;
    m_q <= vcm_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) cpm_mem[p_wa] <= p_wd;
    p_q <= cpm_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) deg_mem[d_wa] <= d_wd;
    d_q <= deg_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) vcl_mem[l_wa] <= l_wd;
    l_q <= vcl_mem[l_ra];
  end

  // drive the search read channel
  always_comb begin
    rsp.edge_q = e_q;
    rsp.vcm_q  = m_q;
    rsp.cpm_q  = p_q;
    rsp.deg_q  = d_q;
    rsp.size   = sizes[req.idx];
    rsp.start  = starts[req.idx];
    rsp.count  = cc;
  end

  assign busy = (st != cmwsb_pkg::ST_IDLE);

endmodule

/* rtl/cmwsb_search.sv */
// ----------------------------------------------------------------------------
// cmwsb_search
// Solve sequencer: orders each cluster by rank, seeds the record, walks the
// depth-first search over the level stack and reports one result per cluster.
// ----------------------------------------------------------------------------
module cmwsb_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          solve_start,
  input  logic [cmwsb_pkg::NODE_W-1:0]  node_limit,
  input  cmwsb_pkg::rd_rsp_t            rsp,
  output cmwsb_pkg::rd_req_t            req,
  output logic                          busy,
  output logic                          result_valid,
  output logic [cmwsb_pkg::VAL_W-1:0]   best_value,
  output logic [cmwsb_pkg::CL_W-1:0]    cluster_index,
  output logic [cmwsb_pkg::VX_W-1:0]    chosen_vertex,
  output logic [cmwsb_pkg::NODE_W-1:0]  nodes_visited,
  output logic                          stopped_early,
  output logic                          last
);

  cmwsb_pkg::search_st_t st, st_next;
  cmwsb_pkg::mode_t      mode;

  logic [cmwsb_pkg::CL_W-1:0]   c, lvl, ci, oc;
  logic [cmwsb_pkg::VC_W-1:0]   x, y, rank;
  logic [cmwsb_pkg::DEG_W-1:0]  dx, sbd;
  logic [cmwsb_pkg::VX_W-1:0]   sb, si;
  logic [cmwsb_pkg::VC_W-1:0]   cp [cmwsb_pkg::MAX_CLUSTERS];
  logic [cmwsb_pkg::CC_W-1:0]   lv, i, j, iend, jend, k;
  logic [cmwsb_pkg::VAL_W-1:0]  acc, best;
  logic [cmwsb_pkg::NODE_W-1:0] cnt;
  logic                         stopped, seeding;
  logic [cmwsb_pkg::VX_W-1:0]   best_sel [cmwsb_pkg::MAX_CLUSTERS];

  // order and partial selection memories
  logic [cmwsb_pkg::VX_W-1:0]   order_mem [cmwsb_pkg::MAX_VERTICES];
  logic [cmwsb_pkg::VX_W-1:0]   sel_mem   [cmwsb_pkg::MAX_CLUSTERS];
  logic                         o_we, s_we;
  logic [cmwsb_pkg::VX_W-1:0]   o_wa, o_ra, o_wd, o_q, s_wd, s_q, smin, smax;
  logic [cmwsb_pkg::CL_W-1:0]   s_wa, s_ra;

  logic [cmwsb_pkg::VC_W-1:0]   s_end;
  logic                         pair_ok, lim_hit, leaf, cp_more;
  logic [cmwsb_pkg::WEIGHT_BITS-1:0] term;

  assign k       = rsp.count;
  assign s_end   = rsp.start + rsp.size;
  assign leaf    = (lv == k);
  assign lim_hit = (node_limit != '0) && (cnt >= node_limit);
  assign cp_more = (cp[lvl] < rsp.size);
  assign smin    = (si < s_q) ? si : s_q;
  assign smax    = (si < s_q) ? s_q : si;

  // loop bounds of the current scan
  always_comb begin
    case (mode)
      cmwsb_pkg::MODE_VAL:  begin iend = lv; jend = lv; term = rsp.edge_q; end
      cmwsb_pkg::MODE_PAIR: begin iend = k;  jend = k;  term = rsp.cpm_q;  end
      cmwsb_pkg::MODE_VCM:  begin iend = lv; jend = k;  term = rsp.vcm_q;  end
      default:              begin iend = '0; jend = '0; term = '0;         end
    endcase
    pair_ok = (i < iend) && (j < jend);
  end

  // read requests to the graph store
  always_comb begin
    req.edge_ra = {smin, smax};
    req.vcm_ra  = {si, j[cmwsb_pkg::CL_W-1:0]};
    req.cpm_ra  = {i[cmwsb_pkg::CL_W-1:0], j[cmwsb_pkg::CL_W-1:0]};
    req.deg_ra  = (st == cmwsb_pkg::S_SORT_Y0) ? y[cmwsb_pkg::VX_W-1:0]
                                               : x[cmwsb_pkg::VX_W-1:0];
    case (st)
      cmwsb_pkg::S_SORT_C, cmwsb_pkg::S_SORT_X0, cmwsb_pkg::S_SORT_X1,
      cmwsb_pkg::S_SORT_Y0, cmwsb_pkg::S_SORT_Y1, cmwsb_pkg::S_SORT_W,
      cmwsb_pkg::S_SORT_SEL: req.idx = c;
      default:               req.idx = lvl;
    endcase
  end

  // memory port control
  always_comb begin
    o_we = (st == cmwsb_pkg::S_SORT_W);
    o_wa = cmwsb_pkg::VX_W'(rsp.start + rank);
    o_wd = x[cmwsb_pkg::VX_W-1:0];
    o_ra = cmwsb_pkg::VX_W'(rsp.start + cp[lvl]);
    s_we = (st == cmwsb_pkg::S_SORT_SEL) || (st == cmwsb_pkg::S_LOAD);
    s_wa = (st == cmwsb_pkg::S_SORT_SEL) ? c : lvl;
    s_wd = (st == cmwsb_pkg::S_SORT_SEL) ? sb : o_q;
    case (st)
      cmwsb_pkg::S_EV_T0: s_ra = i[cmwsb_pkg::CL_W-1:0];
      cmwsb_pkg::S_EV_T1: s_ra = j[cmwsb_pkg::CL_W-1:0];
      cmwsb_pkg::S_CP0:   s_ra = ci;
      default:            s_ra = lvl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_we) order_mem[o_wa] <= o_wd;
    o_q <= order_mem[o_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) sel_mem[s_wa] <= s_wd;
    s_q <= sel_mem[s_ra];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) st <= cmwsb_pkg::S_IDLE;
    else     st <= st_next;
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      cmwsb_pkg::S_IDLE:
        if (solve_start) st_next = (k == '0) ? cmwsb_pkg::S_SEED : cmwsb_pkg::S_SORT_C;
      cmwsb_pkg::S_SORT_C:  st_next = cmwsb_pkg::S_SORT_X0;
      cmwsb_pkg::S_SORT_X0: st_next = cmwsb_pkg::S_SORT_X1;
      cmwsb_pkg::S_SORT_X1: st_next = cmwsb_pkg::S_SORT_Y0;
      cmwsb_pkg::S_SORT_Y0: st_next = cmwsb_pkg::S_SORT_Y1;
      cmwsb_pkg::S_SORT_Y1:
        st_next = (y + cmwsb_pkg::VC_W'(1) == s_end) ? cmwsb_pkg::S_SORT_W
                                                     : cmwsb_pkg::S_SORT_Y0;
      cmwsb_pkg::S_SORT_W:
        st_next = (x + cmwsb_pkg::VC_W'(1) == s_end) ? cmwsb_pkg::S_SORT_SEL
                                                     : cmwsb_pkg::S_SORT_X0;
      cmwsb_pkg::S_SORT_SEL:
        st_next = ({1'b0, c} + cmwsb_pkg::CC_W'(1) == k) ? cmwsb_pkg::S_SEED
                                                         : cmwsb_pkg::S_SORT_C;
      cmwsb_pkg::S_SEED:    st_next = cmwsb_pkg::S_EV_CHK;
      cmwsb_pkg::S_ENTER:   st_next = lim_hit ? cmwsb_pkg::S_OUT : cmwsb_pkg::S_EV_CHK;
      cmwsb_pkg::S_EV_CHK: begin
        if (pair_ok) begin
          st_next = cmwsb_pkg::S_EV_T0;
        end else if (mode == cmwsb_pkg::MODE_VCM ||
                     (mode == cmwsb_pkg::MODE_VAL && leaf)) begin
          st_next = cmwsb_pkg::S_EV_DONE;
        end
      end
      cmwsb_pkg::S_EV_T0:   st_next = cmwsb_pkg::S_EV_T1;
      cmwsb_pkg::S_EV_T1:   st_next = cmwsb_pkg::S_EV_T2;
      cmwsb_pkg::S_EV_T2:   st_next = cmwsb_pkg::S_EV_T3;
      cmwsb_pkg::S_EV_T3:   st_next = cmwsb_pkg::S_EV_CHK;
      cmwsb_pkg::S_EV_DONE: begin
        if (seeding) begin
          st_next = (k == '0) ? cmwsb_pkg::S_ENTER : cmwsb_pkg::S_CP0;
        end else if (leaf) begin
          if (acc > best)      st_next = cmwsb_pkg::S_CP0;
          else if (lv == '0)   st_next = cmwsb_pkg::S_OUT;
          else                 st_next = cmwsb_pkg::S_LOOP;
        end else if (acc <= best && lv == '0) begin
          st_next = cmwsb_pkg::S_OUT;
        end else begin
          st_next = cmwsb_pkg::S_LOOP;
        end
      end
      cmwsb_pkg::S_LOOP: begin
        if (cp_more)           st_next = cmwsb_pkg::S_LOAD;
        else if (lvl == '0)    st_next = cmwsb_pkg::S_OUT;
      end
      cmwsb_pkg::S_LOAD:    st_next = cmwsb_pkg::S_ENTER;
      cmwsb_pkg::S_CP0:     st_next = cmwsb_pkg::S_CP1;
      cmwsb_pkg::S_CP1: begin
        if ({1'b0, ci} + cmwsb_pkg::CC_W'(1) == k)
          st_next = seeding ? cmwsb_pkg::S_ENTER : cmwsb_pkg::S_LOOP;
        else
          st_next = cmwsb_pkg::S_CP0;
      end
      cmwsb_pkg::S_OUT: begin
        if (k == '0 || {1'b0, oc} + cmwsb_pkg::CC_W'(1) == k) st_next = cmwsb_pkg::S_IDLE;
      end
      default: st_next = cmwsb_pkg::S_IDLE;
    endcase
  end

  // datapath: sort counters, scan indices, record and stack
  always_ff @(posedge clk) begin
    case (st)
      cmwsb_pkg::S_IDLE: begin
        if (solve_start) begin
          cnt     <= '0;
          stopped <= 1'b0;
          c       <= '0;
          oc      <= '0;
        end
      end
      cmwsb_pkg::S_SORT_C: x <= rsp.start;
      cmwsb_pkg::S_SORT_X1: begin
        dx   <= rsp.deg_q;
        y    <= rsp.start;
        rank <= '0;
        if (x == rsp.start || sbd < rsp.deg_q) begin
          sb  <= x[cmwsb_pkg::VX_W-1:0];
          sbd <= rsp.deg_q;
        end
      end
      // count the vertices that rank ahead of x
      cmwsb_pkg::S_SORT_Y1: begin
        if (rsp.deg_q > dx || (rsp.deg_q == dx && y > x)) rank <= rank + cmwsb_pkg::VC_W'(1);
        y <= y + cmwsb_pkg::VC_W'(1);
      end
      cmwsb_pkg::S_SORT_W:   x <= x + cmwsb_pkg::VC_W'(1);
      cmwsb_pkg::S_SORT_SEL: c <= c + cmwsb_pkg::CL_W'(1);
      cmwsb_pkg::S_SEED: begin
        lv      <= k;
        seeding <= 1'b1;
        acc     <= '0;
        mode    <= cmwsb_pkg::MODE_VAL;
        i       <= '0;
        j       <= cmwsb_pkg::CC_W'(1);
      end
      cmwsb_pkg::S_ENTER: begin
        if (lim_hit) begin
          stopped <= 1'b1;
        end else begin
          if (cnt != '1) cnt <= cnt + cmwsb_pkg::NODE_W'(1);
          acc  <= '0;
          mode <= cmwsb_pkg::MODE_VAL;
          i    <= '0;
          j    <= cmwsb_pkg::CC_W'(1);
        end
      end
      // move to the next scan when this one is spent
      cmwsb_pkg::S_EV_CHK: begin
        if (!pair_ok) begin
          if (mode == cmwsb_pkg::MODE_VAL && !leaf) begin
            mode <= cmwsb_pkg::MODE_PAIR;
            i    <= lv;
            j    <= lv + cmwsb_pkg::CC_W'(1);
          end else if (mode == cmwsb_pkg::MODE_PAIR) begin
            mode <= cmwsb_pkg::MODE_VCM;
            i    <= '0;
            j    <= lv;
          end
        end
      end
      cmwsb_pkg::S_EV_T1: si <= s_q;
      cmwsb_pkg::S_EV_T3: begin
        acc <= acc + cmwsb_pkg::VAL_W'(term);
        if (j + cmwsb_pkg::CC_W'(1) < jend) begin
          j <= j + cmwsb_pkg::CC_W'(1);
        end else begin
          i <= i + cmwsb_pkg::CC_W'(1);
          j <= (mode == cmwsb_pkg::MODE_VCM) ? lv : i + cmwsb_pkg::CC_W'(2);
        end
      end
      cmwsb_pkg::S_EV_DONE: begin
        ci <= '0;
        if (seeding) begin
          best <= acc;
          lv   <= '0;
          if (k == '0) seeding <= 1'b0;
        end else if (leaf) begin
          if (acc > best) best <= acc;
        end else if (acc > best) begin
          lvl                              <= lv[cmwsb_pkg::CL_W-1:0];
          cp[lv[cmwsb_pkg::CL_W-1:0]]      <= '0;
        end
      end
      cmwsb_pkg::S_LOOP: begin
        if (!cp_more && lvl != '0) lvl <= lvl - cmwsb_pkg::CL_W'(1);
      end
      cmwsb_pkg::S_LOAD: begin
        cp[lvl] <= cp[lvl] + cmwsb_pkg::VC_W'(1);
        lv      <= {1'b0, lvl} + cmwsb_pkg::CC_W'(1);
      end
      cmwsb_pkg::S_CP1: begin
        best_sel[ci] <= s_q;
        ci           <= ci + cmwsb_pkg::CL_W'(1);
        if ({1'b0, ci} + cmwsb_pkg::CC_W'(1) == k) seeding <= 1'b0;
      end
      cmwsb_pkg::S_OUT: oc <= oc + cmwsb_pkg::CL_W'(1);
      default: ;
    endcase
  end

  // register one result per cluster
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= (st == cmwsb_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (st == cmwsb_pkg::S_OUT) begin
      best_value    <= best;
      cluster_index <= oc;
      chosen_vertex <= (k == '0) ? '0 : best_sel[oc];
      nodes_visited <= cnt;
      stopped_early <= stopped;
      last          <= (k == '0) || ({1'b0, oc} + cmwsb_pkg::CC_W'(1) == k);
    end
  end

  assign busy = (st != cmwsb_pkg::S_IDLE);

endmodule

/* rtl/clustered_max_weight_selection_bnb_core.sv */
// ----------------------------------------------------------------------------
// clustered_max_weight_selection_bnb_core
// Clustered maximum-weight selection by branch and bound.
//
// A request is taken at a rising edge with start high and busy low; command
// picks cluster append, edge load or solve. Command 3 is dropped.
// Append: busy while the vertex clusters are filled.
// Edge load: busy while its steps run in turn, each one read or write of a graph memory.
// Solve: busy while the cluster ranking (through the one degree memory
// port), the seed and the search run; the terms of each node's value and
// bound are summed one at a time, as the partial selection memory has a
// single read port. The solve then emits one result per cluster on
// consecutive cycles,
// each marked by result_valid for one cycle; last marks the final one. The
// receiver cannot stall, so results are never held.
// The user must write node_limit through cfg_write/cfg_data only while the
// block is idle; the block does not enforce this. After reset the block
// clears its edge matrix and maxima one entry a cycle, busy high throughout.
// ----------------------------------------------------------------------------
module clustered_max_weight_selection_bnb_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [8:0]  cluster_size,
  input  logic [7:0]  vertex_u,
  input  logic [7:0]  vertex_v,
  input  logic [15:0] edge_weight,
  input  logic        cfg_write,
  input  logic [47:0] cfg_data,
  output logic        result_valid,
  output logic [31:0] best_value,
  output logic [3:0]  cluster_index,
  output logic [7:0]  chosen_vertex,
  output logic [47:0] nodes_visited,
  output logic        stopped_early,
  output logic        last
);

  logic [cmwsb_pkg::NODE_W-1:0] node_limit;
  logic                         accept, load_start, solve_start;
  logic                         store_busy, search_busy;
  cmwsb_pkg::rd_req_t           req;
  cmwsb_pkg::rd_rsp_t           rsp;

  // hold the node limit register
  always_ff @(posedge clk) begin
    if (rst)            node_limit <= '0;
    else if (cfg_write) node_limit <= cfg_data;
  end

  // steer an accepted request
  assign accept      = start && !busy;
  assign load_start  = accept && (command == cmwsb_pkg::CMD_APPEND ||
                                  command == cmwsb_pkg::CMD_EDGE);
  assign solve_start = accept && (command == cmwsb_pkg::CMD_SOLVE);
  assign busy        = store_busy || search_busy;

  cmwsb_store u_store (
    .clk        (clk),
    .rst        (rst),
    .load_start (load_start),
    .load_edge  (command == cmwsb_pkg::CMD_EDGE),
    .size_in    (cluster_size),
    .u_in       (vertex_u),
    .v_in       (vertex_v),
    .w_in       (edge_weight),
    .req        (req),
    .rsp        (rsp),
    .busy       (store_busy)
  );

  cmwsb_search u_search (
    .clk           (clk),
    .rst           (rst),
    .solve_start   (solve_start),
    .node_limit    (node_limit),
    .rsp           (rsp),
    .req           (req),
    .busy          (search_busy),
    .result_valid  (result_valid),
    .best_value    (best_value),
    .cluster_index (cluster_index),
    .chosen_vertex (chosen_vertex),
    .nodes_visited (nodes_visited),
    .stopped_early (stopped_early),
    .last          (last)
  );

endmodule

/* rtl/cmwsb_checker.sv */
// ----------------------------------------------------------------------------
// cmwsb_checker
// Port-level checks on the result burst of a solve.
// ----------------------------------------------------------------------------
`include "clustered_max_weight_selection_bnb_core_defines.svh"

module cmwsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        result_valid,
  input logic        last,
  input logic [3:0]  cluster_index,
  input logic [31:0] best_value,
  input logic [47:0] nodes_visited
);

  // results of one solve come back to back
  `CMWSB_ASSERT_NEXT(a_burst, clk, rst, result_valid && !last, result_valid, "gap in result burst")

  // cluster numbers step by one through the burst
  `CMWSB_ASSERT_NEXT(a_index, clk, rst, result_valid && !last, cluster_index == $past(cluster_index) + 4'd1, "cluster index skipped")

  // the record and the node count stay fixed over the burst
  `CMWSB_ASSERT_NEXT(a_stable, clk, rst, result_valid && !last, $stable(best_value) && $stable(nodes_visited), "record changed in burst")

  // the block stays busy until the final result
  `CMWSB_ASSERT_NOW(a_busy, clk, rst, result_valid && !last, busy, "idle during result burst")

endmodule

bind clustered_max_weight_selection_bnb_core cmwsb_checker u_cmwsb_checker (.*);

/* bench/clustered_max_weight_selection_bnb_core_tb.sv */
// ----------------------------------------------------------------------------
// clustered_max_weight_selection_bnb_core_tb
// Drives cluster appends, edge loads and solves into the selection core. A
// scoreboard class keeps its own copy of the graph and of the branch and bound
// search, predicts every per-cluster result of a solve and checks each result
// as it leaves the block. The node limit is changed between and within phases.
// ----------------------------------------------------------------------------
module clustered_max_weight_selection_bnb_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 400000;
  localparam logic [47:0] CNT_SAT = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  cl;
    logic [7:0]  vtx;
    logic [47:0] nodes;
    logic        stop;
    logic        is_last;
  } pick_t;

  // Graph copy, search predictor and store of expected picks
  class selection_board;
    int unsigned wt[65536];
    int unsigned vclu[256];
    int unsigned csize[16];
    int unsigned cstart[16];
    int unsigned deg[256];
    int unsigned vcmax[4096];
    int unsigned cpmax[256];
    int unsigned order[256];
    int unsigned psel[16];
    int unsigned bsel[16];
    int unsigned cpos[16];
    int unsigned ccount, vcount;
    longint unsigned best, nodes, node_cap;
    pick_t pending_picks[$];
    int errors;

    function longint unsigned pick_value(int unsigned n);
      longint unsigned v;
      v = 0;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) v += wt[psel[i] * 256 + psel[j]];
      return v;
    endfunction

    function longint unsigned bound_rest(int unsigned lvl);
      longint unsigned v;
      v = 0;
      for (int i = lvl; i < ccount; i++)
        for (int j = i + 1; j < ccount; j++) v += cpmax[i * 16 + j];
      for (int i = 0; i < lvl; i++)
        for (int j = lvl; j < ccount; j++) v += vcmax[psel[i] * 16 + j];
      return v;
    endfunction

    // 0 closed, 1 expand, 2 limit reached
    function int visit(int unsigned lvl);
      longint unsigned v;
      if (node_cap != 0 && nodes >= node_cap) return 2;
      if (nodes < CNT_SAT) nodes++;
      v = pick_value(lvl);
      if (lvl == ccount) begin
        if (v > best) begin
          best = v;
          bsel = psel;
        end
        return 0;
      end
      if (v + bound_rest(lvl) <= best) return 0;
      return 1;
    endfunction

    function int unsigned sat_add(int unsigned d, int unsigned w);
      return (d + w > 24'hFFFFFF) ? 24'hFFFFFF : d + w;
    endfunction

    function void load_edge(int unsigned u, int unsigned v, int unsigned w);
      int unsigned cu, cv;
      if (u >= vcount || v >= vcount) return;
      wt[u * 256 + v] = w;
      wt[v * 256 + u] = w;
      deg[u] = sat_add(deg[u], w);
      deg[v] = sat_add(deg[v], w);
      cu = vclu[u];
      cv = vclu[v];
      if (w > vcmax[u * 16 + cv]) vcmax[u * 16 + cv] = w;
      if (w > vcmax[v * 16 + cu]) vcmax[v * 16 + cu] = w;
      if (cu != cv && w > cpmax[cu * 16 + cv]) begin
        cpmax[cu * 16 + cv] = w;
        cpmax[cv * 16 + cu] = w;
      end
    endfunction

    function bit ranks_above(int unsigned a, int unsigned b);
      if (deg[a] != deg[b]) return deg[a] > deg[b];
      return a > b;
    endfunction

    function bit solve_selection();
      int unsigned acc, lvl, s, e, b, j;
      int r;
      bit stopped;
      acc = 0;
      lvl = 0;
      stopped = 0;
      nodes = 0;
      // rank each cluster and seed with its first vertex of top degree
      for (int c = 0; c < ccount; c++) begin
        s = acc;
        e = acc + csize[c];
        b = acc;
        cstart[c] = acc;
        for (int unsigned i = s; i < e; i++) begin
          j = i;
          if (deg[b] < deg[i]) b = i;
          while (j > s && ranks_above(i, order[j - 1])) begin
            order[j] = order[j - 1];
            j--;
          end
          order[j] = i;
        end
        psel[c] = b;
        acc = e;
      end
      best = pick_value(ccount);
      bsel = psel;
      r = visit(0);
      if (r == 2) stopped = 1;
      else if (r == 1) begin
        cpos[0] = 0;
        forever begin
          if (cpos[lvl] < csize[lvl]) begin
            psel[lvl] = order[cstart[lvl] + cpos[lvl]];
            cpos[lvl]++;
            r = visit(lvl + 1);
            if (r == 2) begin
              stopped = 1;
              break;
            end
            if (r == 1) begin
              lvl++;
              cpos[lvl] = 0;
            end
          end else begin
            if (lvl == 0) break;
            lvl--;
          end
        end
      end
      return stopped;
    endfunction

    function void note_request(logic [1:0] cmd, logic [8:0] sz, logic [7:0] u,
                               logic [7:0] v, logic [15:0] w);
      pick_t p;
      bit stopped;
      case (cmd)
        cmwsb_pkg::CMD_APPEND: begin
          if (sz != 0 && ccount < 16 && sz <= 256 - vcount) begin
            for (int i = 0; i < sz; i++) vclu[vcount + i] = ccount;
            csize[ccount] = sz;
            ccount++;
            vcount += sz;
          end
        end
        cmwsb_pkg::CMD_EDGE: load_edge(u, v, w);
        cmwsb_pkg::CMD_SOLVE: begin
          stopped = solve_selection();
          p.value = best[31:0];
          p.nodes = nodes[47:0];
          p.stop = stopped;
          if (ccount == 0) begin
            p.cl = 0;
            p.vtx = 0;
            p.is_last = 1;
            pending_picks = {pending_picks, p};
          end else begin
            for (int c = 0; c < ccount; c++) begin
              p.cl = 4'(c);
              p.vtx = 8'(bsel[c]);
              p.is_last = (c + 1 == ccount);
              pending_picks = {pending_picks, p};
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string f, longint unsigned e, longint unsigned a);
      $display("%0t mismatch %s: expected %0h actual %0h", $time, f, e, a);
      errors++;
    endfunction

    function void check_result(pick_t a);
      pick_t e;
      if (pending_picks.size() == 0) begin
        $display("%0t unexpected result: cluster %0d vertex %0d", $time, a.cl, a.vtx);
        errors++;
        return;
      end
      e = pending_picks.pop_front();
      if (a.value !== e.value) flag("best_value", e.value, a.value);
      if (a.cl !== e.cl) flag("cluster_index", e.cl, a.cl);
      if (a.vtx !== e.vtx) flag("chosen_vertex", e.vtx, a.vtx);
      if (a.nodes !== e.nodes) flag("nodes_visited", e.nodes, a.nodes);
      if (a.stop !== e.stop) flag("stopped_early", e.stop, a.stop);
      if (a.is_last !== e.is_last) flag("last", e.is_last, a.is_last);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  command = cmwsb_pkg::CMD_APPEND;
  logic [8:0]  cluster_size = 0;
  logic [7:0]  vertex_u = 0;
  logic [7:0]  vertex_v = 0;
  logic [15:0] edge_weight = 0;
  logic        cfg_write = 0;
  logic [47:0] cfg_data = 0;
  logic        result_valid;
  logic [31:0] best_value;
  logic [3:0]  cluster_index;
  logic [7:0]  chosen_vertex;
  logic [47:0] nodes_visited;
  logic        stopped_early;
  logic        last;

  selection_board board = new();
  int idle_pct = 0;
  int issued = 0;
  int stall_cycles = 0;

  clustered_max_weight_selection_bnb_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .cluster_size(cluster_size), .vertex_u(vertex_u), .vertex_v(vertex_v),
    .edge_weight(edge_weight), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .result_valid(result_valid), .best_value(best_value),
    .cluster_index(cluster_index), .chosen_vertex(chosen_vertex),
    .nodes_visited(nodes_visited), .stopped_early(stopped_early), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Note accepted requests and check results at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_request(command, cluster_size, vertex_u, vertex_v, edge_weight);
      if (result_valid)
        board.check_result('{best_value, cluster_index, chosen_vertex, nodes_visited,
                             stopped_early, last});
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) stall_cycles <= 0;
    else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL clustered_max_weight_selection_bnb_core");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  task automatic issue(logic [1:0] cmd, logic [8:0] sz, logic [7:0] u, logic [7:0] v,
                       logic [15:0] w);
    // rotate the sender idling every 40 requests
    case ((issued / 40) % 4)
      0: idle_pct = 0;
      1: idle_pct = 71;
      2: idle_pct = 0;
      default: idle_pct = 32;
    endcase
    issued++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    cluster_size <= sz;
    vertex_u <= u;
    vertex_v <= v;
    edge_weight <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain all picks, then let the block settle
  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (board.pending_picks.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [47:0] lim);
    wait_idle();
    cfg_write <= 1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_write <= 0;
    board.node_cap = lim;
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic random_edge(int unsigned span);
    issue(cmwsb_pkg::CMD_EDGE, 9'($urandom_range(511)), 8'($urandom_range(span)),
          8'($urandom_range(span)), pick_weight());
  endtask

  initial begin
    int unsigned sz;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: empty solve, bad appends, special edges
    set_limit(0);
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 0, 8'hFF, 8'hFF, 16'hFFFF);
    issue(cmwsb_pkg::CMD_APPEND, 1, 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 3, 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 9'h1FF, 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 2, 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 2, 0, 0, 0);
    issue(cmwsb_pkg::CMD_EDGE, 0, 0, 1, 16'hFFFF);
    issue(cmwsb_pkg::CMD_EDGE, 0, 1, 4, 7);
    issue(cmwsb_pkg::CMD_EDGE, 0, 2, 2, 300);
    issue(cmwsb_pkg::CMD_EDGE, 0, 0, 200, 5);
    issue(cmwsb_pkg::CMD_EDGE, 0, 3, 5, 0);
    issue(cmwsb_pkg::CMD_EDGE, 0, 0, 1, 10);
    issue(cmwsb_pkg::CMD_EDGE, 0, 4, 7, 16'hFFFF);
    issue(cmwsb_pkg::CMD_EDGE, 0, 6, 2, 1234);
    issue(CMD_SPARE, 9'h1FF, 8'hFF, 8'hFF, 16'hFFFF);
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);
    set_limit(1);
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);
    set_limit(CNT_SAT);
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);

    // Random loads and solves on the small graph, limit at its top
    for (int n = 0; n < 150; n++) begin
      if (n == 75) wait_idle();
      case ($urandom_range(19))
        0, 1: issue(cmwsb_pkg::CMD_SOLVE, 9'($urandom_range(511)), 0, 0, 0);
        2: issue(CMD_SPARE, 9'($urandom_range(511)), 8'($urandom_range(255)), 0, 0);
        default: random_edge(15);
      endcase
    end
    // saturate one degree with heavy self edges
    for (int n = 0; n < 130; n++) issue(cmwsb_pkg::CMD_EDGE, 0, 0, 0, 16'hFFFF);
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);

    // Fill to every cluster and every vertex, then search under small limits
    set_limit(48'($urandom_range(6, 2)));
    for (int c = 0; c < 11; c++)
      issue(cmwsb_pkg::CMD_APPEND, 9'($urandom_range(22, 18)), 0, 0, 0);
    sz = 256 - board.vcount;
    issue(cmwsb_pkg::CMD_APPEND, 9'(sz + 1), 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 9'(sz), 0, 0, 0);
    issue(cmwsb_pkg::CMD_APPEND, 1, 0, 0, 0);
    for (int n = 0; n < 200; n++) begin
      if (n == 70) set_limit(1);
      if (n == 140) set_limit(48'($urandom_range(8, 2)));
      case ($urandom_range(24))
        0, 1: issue(cmwsb_pkg::CMD_SOLVE, 9'($urandom_range(511)), 0, 0, 0);
        2: issue(cmwsb_pkg::CMD_APPEND, 9'($urandom_range(511)), 0, 0, 0);
        3: issue(CMD_SPARE, 9'($urandom_range(511)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), pick_weight());
        default: random_edge(255);
      endcase
    end
    issue(cmwsb_pkg::CMD_SOLVE, 0, 0, 0, 0);

    // Drain and report
    wait_idle();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending_picks.size() == 0)
      $display("PASS clustered_max_weight_selection_bnb_core");
    else
      $display("FAIL clustered_max_weight_selection_bnb_core");
    $finish;
  end
endmodule
